/* design/fmbs_pkg.sv */
`default_nettype none

package fmbs_pkg;

  // field widths
  localparam int unsigned SAMPLE_W = 13;
  localparam int unsigned TICK_W   = 16;
  localparam int unsigned THR_W    = 13;

  // moving average length and derived arithmetic
  localparam int unsigned AVG_LEN   = 7;
  localparam int unsigned SUM_W     = $clog2(((1 << SAMPLE_W) - 1) * AVG_LEN + 1);
  localparam int unsigned LEN_LOG   = $clog2(AVG_LEN);
  // reciprocal of AVG_LEN, rounded up, exact for every sum below 2**SUM_W
  localparam int unsigned DIV_SHIFT = SUM_W + LEN_LOG;
  localparam int unsigned RECIP_W   = DIV_SHIFT - LEN_LOG + 1;
  localparam int unsigned RECIP     = (2 ** DIV_SHIFT) / AVG_LEN + 1;

  // register reset values
  localparam logic [TICK_W-1:0] TAKEOFF_RST = TICK_W'(200);
  localparam logic [TICK_W-1:0] LANDING_RST = TICK_W'(200);
  localparam logic [THR_W-1:0]  FLY_MV_RST  = THR_W'(3000);
  localparam logic [THR_W-1:0]  IDLE_MV_RST = THR_W'(3400);

  // register indexes
  localparam logic [1:0] REG_TAKEOFF = 2'd0;
  localparam logic [1:0] REG_LANDING = 2'd1;
  localparam logic [1:0] REG_FLY_MV  = 2'd2;
  localparam logic [1:0] REG_IDLE_MV = 2'd3;

  typedef enum logic [1:0] {
    KIND_CMD    = 2'd0,
    KIND_RADIO  = 2'd1,
    KIND_SAMPLE = 2'd2,
    KIND_TICK   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    MODE_OFF     = 2'd0,
    MODE_TAKEOFF = 2'd1,
    MODE_FLYING  = 2'd2,
    MODE_LAND    = 2'd3
  } mode_t;

  // command codes
  localparam logic [1:0] CMD_TAKEOFF = 2'd0;
  localparam logic [1:0] CMD_LAND    = 2'd1;
  localparam logic [1:0] CMD_OFF     = 2'd2;

  // averager status toward the mode controller
  typedef struct packed {
    logic                below_fly;
    logic                below_idle;
    logic [SAMPLE_W-1:0] filtered;
  } avg_stat_t;

  // one result beat
  typedef struct packed {
    mode_t               mode;
    logic                low;
    logic [SAMPLE_W-1:0] filtered;
    logic                changed;
  } result_t;

endpackage

`default_nettype wire

/* design/fmbs_cell.sv */
`default_nettype none

module fmbs_cell (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          shift_en,
  input  wire logic [fmbs_pkg::SAMPLE_W-1:0] d_in,
  output logic      [fmbs_pkg::SAMPLE_W-1:0] q_out
);

  logic [fmbs_pkg::SAMPLE_W-1:0] q_r;
  logic [fmbs_pkg::SAMPLE_W-1:0] q_nxt;

  // take the neighbor's sample on a shift
  always_comb begin
    q_nxt = shift_en ? d_in : q_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else begin
      q_r <= q_nxt;
    end
  end

  assign q_out = q_r;

endmodule

`default_nettype wire

/* design/fmbs_avg.sv */
`default_nettype none

module fmbs_avg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          shift_en,
  input  wire logic [fmbs_pkg::SAMPLE_W-1:0] sample,
  input  wire logic [fmbs_pkg::SUM_W-1:0]    fly_lim,
  input  wire logic [fmbs_pkg::SUM_W-1:0]    idle_lim,
  output fmbs_pkg::avg_stat_t                stat
);

  localparam int unsigned PROD_W = fmbs_pkg::SUM_W + fmbs_pkg::RECIP_W;
  localparam logic [fmbs_pkg::RECIP_W-1:0] RECIP_K = fmbs_pkg::RECIP_W'(fmbs_pkg::RECIP);

  logic [fmbs_pkg::SAMPLE_W-1:0] tap [fmbs_pkg::AVG_LEN];
  logic [fmbs_pkg::SUM_W-1:0]    sum_r;
  logic [fmbs_pkg::SUM_W-1:0]    sum_nxt;
  logic [fmbs_pkg::SUM_W-1:0]    sum_sel;
  logic [PROD_W-1:0]             prod;

  // sample delay line, one cell per tap
  for (genvar i = 0; i < fmbs_pkg::AVG_LEN; i++) begin : g_line
    if (i == 0) begin : g_head
      fmbs_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .d_in     (sample),
        .q_out    (tap[i])
      );
    end else begin : g_body
      fmbs_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .d_in     (tap[i-1]),
        .q_out    (tap[i])
      );
    end
  end

  // running sum: add newest, drop oldest
  always_comb begin
    sum_nxt = sum_r + fmbs_pkg::SUM_W'(sample)
            - fmbs_pkg::SUM_W'(tap[fmbs_pkg::AVG_LEN-1]);
    sum_sel = shift_en ? sum_nxt : sum_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else begin
      sum_r <= sum_sel;
    end
  end

  // divide by the length through the reciprocal
  assign prod = PROD_W'(sum_sel) * PROD_W'(RECIP_K);

  // floor(sum / N) < t  is the same as  sum < N * t
  always_comb begin
    stat.below_fly  = sum_nxt < fly_lim;
    stat.below_idle = sum_nxt < idle_lim;
    stat.filtered   = prod[fmbs_pkg::DIV_SHIFT +: fmbs_pkg::SAMPLE_W];
  end

endmodule

`default_nettype wire

/* design/fmbs_ctrl.sv */
`default_nettype none

module fmbs_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        beat_en,
  input  wire fmbs_pkg::kind_t             kind,
  input  wire logic [1:0]                  cmd,
  input  wire logic                        link_up,
  input  wire logic [fmbs_pkg::TICK_W-1:0] takeoff_ticks,
  input  wire logic [fmbs_pkg::TICK_W-1:0] landing_ticks,
  input  wire fmbs_pkg::avg_stat_t         stat,
  output fmbs_pkg::result_t                res
);

  fmbs_pkg::mode_t             mode_r, mode_nxt;
  logic                        link_r, link_nxt;
  logic                        low_r, low_nxt;
  logic [fmbs_pkg::TICK_W-1:0] phase_r, phase_nxt;

  logic                        req;
  fmbs_pkg::mode_t             target;
  logic                        low_now;
  logic [fmbs_pkg::TICK_W-1:0] phase_inc;
  logic [fmbs_pkg::TICK_W-1:0] limit;

  // event decode and next state
  always_comb begin
    link_nxt  = link_r;
    low_nxt   = low_r;
    phase_nxt = phase_r;
    req       = 1'b0;
    target    = fmbs_pkg::MODE_OFF;
    low_now   = (mode_r != fmbs_pkg::MODE_OFF) ? stat.below_fly : stat.below_idle;
    phase_inc = (phase_r == '1) ? phase_r : phase_r + 1'b1;
    limit     = (mode_r == fmbs_pkg::MODE_TAKEOFF) ? takeoff_ticks : landing_ticks;

    case (kind)
      fmbs_pkg::KIND_CMD: begin
        case (cmd)
          fmbs_pkg::CMD_TAKEOFF: begin
            req    = (mode_r == fmbs_pkg::MODE_OFF);
            target = fmbs_pkg::MODE_TAKEOFF;
          end
          fmbs_pkg::CMD_LAND: begin
            req    = (mode_r != fmbs_pkg::MODE_OFF);
            target = fmbs_pkg::MODE_LAND;
          end
          fmbs_pkg::CMD_OFF: begin
            req    = 1'b1;
            target = fmbs_pkg::MODE_OFF;
          end
          default: ;
        endcase
      end
      fmbs_pkg::KIND_RADIO: begin
        link_nxt = link_up;
      end
      fmbs_pkg::KIND_SAMPLE: begin
        if (low_now) begin
          low_nxt = 1'b1;
          // entering low battery while airborne forces landing
          req     = !low_r && (mode_r != fmbs_pkg::MODE_OFF);
          target  = fmbs_pkg::MODE_LAND;
        end else begin
          low_nxt = 1'b0;
        end
      end
      fmbs_pkg::KIND_TICK: begin
        if (mode_r == fmbs_pkg::MODE_TAKEOFF || mode_r == fmbs_pkg::MODE_LAND) begin
          phase_nxt = phase_inc;
          req       = (phase_inc >= limit);
          target    = (mode_r == fmbs_pkg::MODE_TAKEOFF) ? fmbs_pkg::MODE_FLYING
                                                         : fmbs_pkg::MODE_OFF;
        end
      end
      default: ;
    endcase

    // change request: link down sends motors off, timer restarts
    mode_nxt = mode_r;
    if (req) begin
      mode_nxt  = link_r ? target : fmbs_pkg::MODE_OFF;
      phase_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= fmbs_pkg::MODE_OFF;
      link_r  <= 1'b0;
      low_r   <= 1'b0;
      phase_r <= '0;
    end else if (beat_en) begin
      mode_r  <= mode_nxt;
      link_r  <= link_nxt;
      low_r   <= low_nxt;
      phase_r <= phase_nxt;
    end
  end

  // result of this beat
  always_comb begin
    res.mode     = mode_nxt;
    res.low      = low_nxt;
    res.filtered = stat.filtered;
    res.changed  = req;
  end

endmodule

`default_nettype wire

/* design/flight_mode_battery_supervisor_core.sv */
`default_nettype none

// Flight mode and battery supervisor.
// Input channel (in_valid / in_stall) carries one event per beat: a command,
// a radio link status, a battery sample or a timer tick, chosen by in_kind.
// Every input beat yields exactly one result beat on the out_ channel with
// the mode, battery-low flag and filtered voltage after that event, and a
// flag telling whether the event requested a mode change.
// The result is registered at the edge that accepts the event. Throughput
// is one event per cycle while in_stall is low; the mode and timer update
// and the running-sum step of the sample line all close at that edge.
// A two-entry output stage (output register plus skid register) lets the
// block accept while a result waits; in_stall rises only once both hold a
// result the receiver has not taken, and results are kept in order.
// Battery samples shift through a line of seven cells; their sum is kept
// exactly and divided by seven with a reciprocal multiply. Registers are
// written through the cfg_ APB port while the block is idle (user's rule,
// not enforced). Synchronous reset: motors off, link down, flag normal,
// sample line and sum cleared, registers at defaults, no result pending.

module flight_mode_battery_supervisor_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // event channel
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [1:0]                      in_kind,
  input  wire logic [1:0]                      in_command_code,
  input  wire logic                            in_link_up,
  input  wire logic [fmbs_pkg::SAMPLE_W-1:0]   in_sample_mv,
  // result channel
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [1:0]                           out_flight_mode,
  output logic                                 out_battery_low,
  output logic [fmbs_pkg::SAMPLE_W-1:0]        out_filtered_mv,
  output logic                                 out_mode_changed,
  // configuration
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [3:0]                      cfg_paddr,
  input  wire logic [31:0]                     cfg_pwdata,
  output logic [31:0]                          cfg_prdata,
  output logic                                 cfg_pready
);

  localparam logic [fmbs_pkg::SUM_W-1:0] LEN_S = fmbs_pkg::SUM_W'(fmbs_pkg::AVG_LEN);

  logic [fmbs_pkg::TICK_W-1:0] takeoff_r, landing_r;
  logic [fmbs_pkg::THR_W-1:0]  fly_mv_r, idle_mv_r;
  logic [fmbs_pkg::SUM_W-1:0]  fly_lim_r, idle_lim_r;
  logic                        cfg_wr;
  logic [1:0]                  cfg_idx;
  logic [fmbs_pkg::THR_W-1:0]  wr_mv;
  logic [fmbs_pkg::SUM_W-1:0]  wr_lim;

  logic                        accept;
  logic                        shift_en;
  fmbs_pkg::avg_stat_t         stat;
  fmbs_pkg::result_t           res;

  fmbs_pkg::result_t           out_r, skid_r;
  logic                        out_vld_r, skid_vld_r;
  logic                        out_free;

  // register port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[3:2];
  assign wr_mv      = cfg_pwdata[fmbs_pkg::THR_W-1:0];
  // thresholds kept pre-scaled by the average length for the sum compare
  assign wr_lim     = fmbs_pkg::SUM_W'(wr_mv) * LEN_S;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      takeoff_r  <= fmbs_pkg::TAKEOFF_RST;
      landing_r  <= fmbs_pkg::LANDING_RST;
      fly_mv_r   <= fmbs_pkg::FLY_MV_RST;
      idle_mv_r  <= fmbs_pkg::IDLE_MV_RST;
      fly_lim_r  <= fmbs_pkg::SUM_W'(fmbs_pkg::FLY_MV_RST) * LEN_S;
      idle_lim_r <= fmbs_pkg::SUM_W'(fmbs_pkg::IDLE_MV_RST) * LEN_S;
    end else if (cfg_wr) begin
      case (cfg_idx)
        fmbs_pkg::REG_TAKEOFF: takeoff_r <= cfg_pwdata[fmbs_pkg::TICK_W-1:0];
        fmbs_pkg::REG_LANDING: landing_r <= cfg_pwdata[fmbs_pkg::TICK_W-1:0];
        fmbs_pkg::REG_FLY_MV: begin
          fly_mv_r  <= wr_mv;
          fly_lim_r <= wr_lim;
        end
        fmbs_pkg::REG_IDLE_MV: begin
          idle_mv_r  <= wr_mv;
          idle_lim_r <= wr_lim;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      fmbs_pkg::REG_TAKEOFF: cfg_prdata = 32'(takeoff_r);
      fmbs_pkg::REG_LANDING: cfg_prdata = 32'(landing_r);
      fmbs_pkg::REG_FLY_MV:  cfg_prdata = 32'(fly_mv_r);
      fmbs_pkg::REG_IDLE_MV: cfg_prdata = 32'(idle_mv_r);
      default:               cfg_prdata = '0;
    endcase
  end

  // input beat
  assign in_stall = skid_vld_r;
  assign accept   = in_valid && !skid_vld_r;
  assign shift_en = accept && (fmbs_pkg::kind_t'(in_kind) == fmbs_pkg::KIND_SAMPLE);

  fmbs_avg u_avg (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (shift_en),
    .sample   (in_sample_mv),
    .fly_lim  (fly_lim_r),
    .idle_lim (idle_lim_r),
    .stat     (stat)
  );

  fmbs_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .beat_en       (accept),
    .kind          (fmbs_pkg::kind_t'(in_kind)),
    .cmd           (in_command_code),
    .link_up       (in_link_up),
    .takeoff_ticks (takeoff_r),
    .landing_ticks (landing_r),
    .stat          (stat),
    .res           (res)
  );

  // output register with skid stage
  assign out_free = !out_vld_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r  <= skid_vld_r || accept;
      skid_vld_r <= 1'b0;
    end else if (accept) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_r <= skid_vld_r ? skid_r : res;
    end else if (accept) begin
      skid_r <= res;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_flight_mode  = out_r.mode;
  assign out_battery_low  = out_r.low;
  assign out_filtered_mv  = out_r.filtered;
  assign out_mode_changed = out_r.changed;

endmodule

`default_nettype wire

/* verif/flight_mode_battery_supervisor_core_tb.sv */
`timescale 1ns / 1ps

module flight_mode_battery_supervisor_core_tb;

  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned RAND_PHASES = 8;
  localparam int unsigned PHASE_BEATS = 200;
  localparam int unsigned LONG_TAKEOFF = 300;

  // one event beat as the sender presents it
  typedef struct packed {
    fmbs_pkg::kind_t               kind;
    logic [1:0]                    cmd;
    logic                          link;
    logic [fmbs_pkg::SAMPLE_W-1:0] sample;
  } ev_t;

  // directed row: event plus an optional hand-written result
  typedef struct packed {
    ev_t               ev;
    logic              typed;
    fmbs_pkg::result_t want;
  } dir_row_t;

  localparam fmbs_pkg::result_t NO_CHECK = '{fmbs_pkg::MODE_OFF, 1'b0, 13'd0, 1'b0};

  // clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // block ports
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [1:0]                    in_kind = 2'd0;
  logic [1:0]                    in_command_code = 2'd0;
  logic                          in_link_up = 1'b0;
  logic [fmbs_pkg::SAMPLE_W-1:0] in_sample_mv = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [1:0]                    out_flight_mode;
  logic                          out_battery_low;
  logic [fmbs_pkg::SAMPLE_W-1:0] out_filtered_mv;
  logic                          out_mode_changed;
  logic                          cfg_psel = 1'b0;
  logic                          cfg_penable = 1'b0;
  logic                          cfg_pwrite = 1'b0;
  logic [3:0]                    cfg_paddr = 4'd0;
  logic [31:0]                   cfg_pwdata = 32'd0;
  logic [31:0]                   cfg_prdata;
  logic                          cfg_pready;

  flight_mode_battery_supervisor_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_command_code  (in_command_code),
    .in_link_up       (in_link_up),
    .in_sample_mv     (in_sample_mv),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_flight_mode  (out_flight_mode),
    .out_battery_low  (out_battery_low),
    .out_filtered_mv  (out_filtered_mv),
    .out_mode_changed (out_mode_changed),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready)
  );

  // supervisor copy: registers
  logic [fmbs_pkg::TICK_W-1:0] sv_takeoff = fmbs_pkg::TAKEOFF_RST;
  logic [fmbs_pkg::TICK_W-1:0] sv_landing = fmbs_pkg::LANDING_RST;
  logic [fmbs_pkg::THR_W-1:0]  sv_fly_mv  = fmbs_pkg::FLY_MV_RST;
  logic [fmbs_pkg::THR_W-1:0]  sv_idle_mv = fmbs_pkg::IDLE_MV_RST;

  // supervisor copy: state
  fmbs_pkg::mode_t               sv_mode = fmbs_pkg::MODE_OFF;
  logic                          sv_link = 1'b0;
  logic [fmbs_pkg::TICK_W-1:0]   sv_phase = '0;
  logic                          sv_low = 1'b0;
  logic [fmbs_pkg::SAMPLE_W-1:0] sv_line [fmbs_pkg::AVG_LEN];
  logic [fmbs_pkg::SUM_W-1:0]    sv_sum = '0;

  initial begin
    for (int i = 0; i < fmbs_pkg::AVG_LEN; i++) sv_line[i] = '0;
  end

  fmbs_pkg::result_t status_due [$];
  int unsigned mismatches = 0;
  int unsigned events_sent = 0;
  int unsigned results_seen = 0;
  int unsigned settings_used = 0;
  int unsigned quiet_cycles = 0;
  int unsigned tx_odds = 0;
  int unsigned rx_odds = 0;
  int unsigned rx_hold = 0;
  int          bat_mv = 4000;

  // mode change request: honored only with the link up
  function automatic void enter_mode(fmbs_pkg::mode_t target);
    if (sv_link) sv_mode = target;
    else sv_mode = fmbs_pkg::MODE_OFF;
    sv_phase = '0;
  endfunction

  // next status of the supervisor for one event
  function automatic fmbs_pkg::result_t supervise(ev_t e);
    fmbs_pkg::result_t r;
    logic changed;
    logic low;
    logic [fmbs_pkg::SAMPLE_W-1:0] avg;
    logic [fmbs_pkg::TICK_W-1:0] limit;
    int i;
    changed = 1'b0;
    case (e.kind)
      fmbs_pkg::KIND_CMD: begin
        if (e.cmd == fmbs_pkg::CMD_TAKEOFF) begin
          if (sv_mode == fmbs_pkg::MODE_OFF) begin
            enter_mode(fmbs_pkg::MODE_TAKEOFF);
            changed = 1'b1;
          end
        end else if (e.cmd == fmbs_pkg::CMD_LAND) begin
          if (sv_mode != fmbs_pkg::MODE_OFF) begin
            enter_mode(fmbs_pkg::MODE_LAND);
            changed = 1'b1;
          end
        end else if (e.cmd == fmbs_pkg::CMD_OFF) begin
          enter_mode(fmbs_pkg::MODE_OFF);
          changed = 1'b1;
        end
      end
      fmbs_pkg::KIND_RADIO: sv_link = e.link;
      fmbs_pkg::KIND_SAMPLE: begin
        sv_sum = sv_sum + fmbs_pkg::SUM_W'(e.sample)
               - fmbs_pkg::SUM_W'(sv_line[fmbs_pkg::AVG_LEN-1]);
        for (i = fmbs_pkg::AVG_LEN - 1; i > 0; i--) sv_line[i] = sv_line[i-1];
        sv_line[0] = e.sample;
        avg = fmbs_pkg::SAMPLE_W'(sv_sum / fmbs_pkg::AVG_LEN);
        // threshold follows the mode before this event
        if (sv_mode != fmbs_pkg::MODE_OFF) low = (avg < sv_fly_mv);
        else low = (avg < sv_idle_mv);
        if (low) begin
          if (!sv_low) begin
            sv_low = 1'b1;
            if (sv_mode != fmbs_pkg::MODE_OFF) begin
              enter_mode(fmbs_pkg::MODE_LAND);
              changed = 1'b1;
            end
          end
        end else begin
          sv_low = 1'b0;
        end
      end
      default: begin
        if (sv_mode == fmbs_pkg::MODE_TAKEOFF || sv_mode == fmbs_pkg::MODE_LAND) begin
          if (sv_mode == fmbs_pkg::MODE_TAKEOFF) limit = sv_takeoff;
          else limit = sv_landing;
          if (sv_phase != '1) sv_phase = sv_phase + 1'b1;
          if (sv_phase >= limit) begin
            if (sv_mode == fmbs_pkg::MODE_TAKEOFF) enter_mode(fmbs_pkg::MODE_FLYING);
            else enter_mode(fmbs_pkg::MODE_OFF);
            changed = 1'b1;
          end
        end
      end
    endcase
    r.mode = sv_mode;
    r.low = sv_low;
    r.filtered = fmbs_pkg::SAMPLE_W'(sv_sum / fmbs_pkg::AVG_LEN);
    r.changed = changed;
    return r;
  endfunction

  // random event: mostly sane flight sequences, battery on a drifting level
  function automatic ev_t pick_event();
    ev_t e;
    int roll;
    int mv;
    e.cmd = 2'($urandom);
    e.link = 1'($urandom);
    e.sample = fmbs_pkg::SAMPLE_W'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 15) begin
      e.kind = fmbs_pkg::KIND_CMD;
      roll = $urandom_range(0, 99);
      if (roll < 50) e.cmd = fmbs_pkg::CMD_TAKEOFF;
      else if (roll < 70) e.cmd = fmbs_pkg::CMD_LAND;
      else if (roll < 85) e.cmd = fmbs_pkg::CMD_OFF;
      else e.cmd = CMD_UNKNOWN;
    end else if (roll < 20) begin
      e.kind = fmbs_pkg::KIND_RADIO;
      e.link = ($urandom_range(0, 9) != 0);
    end else if (roll < 55) begin
      e.kind = fmbs_pkg::KIND_SAMPLE;
      if ($urandom_range(0, 99) < 3) bat_mv = $urandom_range(0, 8191);
      bat_mv = bat_mv + $urandom_range(0, 500) - 250;
      if (bat_mv < 0) bat_mv = 0;
      if (bat_mv > 8191) bat_mv = 8191;
      if ($urandom_range(0, 99) >= 15) begin
        mv = bat_mv + $urandom_range(0, 200) - 100;
        if (mv < 0) mv = 0;
        if (mv > 8191) mv = 8191;
        e.sample = fmbs_pkg::SAMPLE_W'(mv);
      end
    end else begin
      e.kind = fmbs_pkg::KIND_TICK;
    end
    return e;
  endfunction

  function automatic int unsigned pick_odds();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 8;
      default: return 3;
    endcase
  endfunction

  // one mismatch: one line and a count
  task automatic flag_mismatch(string what, int got, int want);
    $display("mismatch in %s at result %0d: got %0d, expected %0d",
             what, results_seen, got, want);
    mismatches++;
  endtask

  // present one event beat, hold it until taken, then record its status
  task automatic drive_event(ev_t e, logic typed, fmbs_pkg::result_t want);
    fmbs_pkg::result_t predicted;
    int gap;
    if (tx_odds != 0 && $urandom_range(1, tx_odds) == 1) begin
      gap = $urandom_range(1, 17);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= e.kind;
    in_command_code <= e.cmd;
    in_link_up <= e.link;
    in_sample_mv <= e.sample;
    do @(posedge clk); while (in_stall);
    predicted = supervise(e);
    if (typed) status_due.push_back(want);
    else status_due.push_back(predicted);
    events_sent++;
  endtask

  // drop valid and let every pending result drain
  task automatic drain();
    in_valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // APB write: setup phase, access phase, then idle
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      fmbs_pkg::REG_TAKEOFF: sv_takeoff = fmbs_pkg::TICK_W'(val);
      fmbs_pkg::REG_LANDING: sv_landing = fmbs_pkg::TICK_W'(val);
      fmbs_pkg::REG_FLY_MV:  sv_fly_mv = fmbs_pkg::THR_W'(val);
      fmbs_pkg::REG_IDLE_MV: sv_idle_mv = fmbs_pkg::THR_W'(val);
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_settings(int unsigned t, int unsigned l, int unsigned f, int unsigned d);
    write_reg(fmbs_pkg::REG_TAKEOFF, t);
    write_reg(fmbs_pkg::REG_LANDING, l);
    write_reg(fmbs_pkg::REG_FLY_MV, f);
    write_reg(fmbs_pkg::REG_IDLE_MV, d);
    settings_used++;
  endtask

  // directed rows; thresholds at reset, take-off 3 ticks, landing 1 tick
  dir_row_t dir_rows [26] = '{
    '{'{fmbs_pkg::KIND_TICK, fmbs_pkg::CMD_TAKEOFF, 1'b0, 13'd0}, 1'b1,
      '{fmbs_pkg::MODE_OFF, 1'b0, 13'd0, 1'b0}},
    '{'{fmbs_pkg::KIND_CMD, fmbs_pkg::CMD_TAKEOFF, 1'b1, 13'd8191}, 1'b1,
      '{fmbs_pkg::MODE_OFF, 1'b0, 13'd0, 1'b1}},
    '{'{fmbs_pkg::KIND_CMD, fmbs_pkg::CMD_LAND, 1'b0, 13'd0}, 1'b1,
      '{fmbs_pkg::MODE_OFF, 1'b0, 13'd0, 1'b0}},
    '{'{fmbs_pkg::KIND_CMD, CMD_UNKNOWN, 1'b1, 13'd0}, 1'b1,
      '{fmbs_pkg::MODE_OFF, 1'b0, 13'd0, 1'b0}},
    '{'{fmbs_pkg::KIND_CMD, fmbs_pkg::CMD_OFF, 1'b0, 13'd0}, 1'b1,
      '{fmbs_pkg::MODE_OFF, 1'b0, 13'd0, 1'b1}},
    '{'{fmbs_pkg::KIND_SAMPLE, CMD_UNKNOWN, 1'b1, 13'd0}, 1'b1,
      '{fmbs_pkg::MODE_OFF, 1'b1, 13'd0, 1'b0}},
    '{'{fmbs_pkg::KIND_SAMPLE, fmbs_pkg::CMD_OFF, 1'b0, 13'd8191}, 1'b1,
      '{fmbs_pkg::MODE_OFF, 1'b1, 13'd1170, 1'b0}},
    '{'{fmbs_pkg::KIND_RADIO, CMD_UNKNOWN, 1'b1, 13'd8191}, 1'b1,
      '{fmbs_pkg::MODE_OFF, 1'b1, 13'd1170, 1'b0}},
    '{'{fmbs_pkg::KIND_CMD, fmbs_pkg::CMD_TAKEOFF, 1'b0, 13'd0}, 1'b1,
      '{fmbs_pkg::MODE_TAKEOFF, 1'b1, 13'd1170, 1'b1}},
    '{'{fmbs_pkg::KIND_CMD, fmbs_pkg::CMD_TAKEOFF, 1'b0, 13'd0}, 1'b1,
      '{fmbs_pkg::MODE_TAKEOFF, 1'b1, 13'd1170, 1'b0}},
    '{'{fmbs_pkg::KIND_SAMPLE, fmbs_pkg::CMD_TAKEOFF, 1'b0, 13'd8191}, 1'b0, NO_CHECK},
    '{'{fmbs_pkg::KIND_SAMPLE, fmbs_pkg::CMD_TAKEOFF, 1'b0, 13'd8191}, 1'b0, NO_CHECK},
    '{'{fmbs_pkg::KIND_SAMPLE, fmbs_pkg::CMD_TAKEOFF, 1'b0, 13'd8191}, 1'b0, NO_CHECK},
    '{'{fmbs_pkg::KIND_SAMPLE, fmbs_pkg::CMD_TAKEOFF, 1'b0, 13'd8191}, 1'b0, NO_CHECK},
    '{'{fmbs_pkg::KIND_SAMPLE, fmbs_pkg::CMD_TAKEOFF, 1'b0, 13'd8191}, 1'b0, NO_CHECK},
    '{'{fmbs_pkg::KIND_SAMPLE, fmbs_pkg::CMD_LAND, 1'b1, 13'd8191}, 1'b1,
      '{fmbs_pkg::MODE_TAKEOFF, 1'b0, 13'd8191, 1'b0}},
    '{'{fmbs_pkg::KIND_TICK, fmbs_pkg::CMD_OFF, 1'b0, 13'd0}, 1'b0, NO_CHECK},
    '{'{fmbs_pkg::KIND_TICK, fmbs_pkg::CMD_OFF, 1'b0, 13'd0}, 1'b0, NO_CHECK},
    '{'{fmbs_pkg::KIND_TICK, fmbs_pkg::CMD_OFF, 1'b0, 13'd0}, 1'b0, NO_CHECK},
    '{'{fmbs_pkg::KIND_SAMPLE, fmbs_pkg::CMD_TAKEOFF, 1'b0, 13'd0}, 1'b0, NO_CHECK},
    '{'{fmbs_pkg::KIND_SAMPLE, fmbs_pkg::CMD_TAKEOFF, 1'b0, 13'd0}, 1'b0, NO_CHECK},
    '{'{fmbs_pkg::KIND_SAMPLE, fmbs_pkg::CMD_TAKEOFF, 1'b0, 13'd0}, 1'b0, NO_CHECK},
    '{'{fmbs_pkg::KIND_SAMPLE, fmbs_pkg::CMD_TAKEOFF, 1'b0, 13'd0}, 1'b0, NO_CHECK},
    '{'{fmbs_pkg::KIND_SAMPLE, fmbs_pkg::CMD_TAKEOFF, 1'b0, 13'd0}, 1'b0, NO_CHECK},
    '{'{fmbs_pkg::KIND_TICK, fmbs_pkg::CMD_OFF, 1'b0, 13'd0}, 1'b0, NO_CHECK},
    '{'{fmbs_pkg::KIND_RADIO, fmbs_pkg::CMD_TAKEOFF, 1'b0, 13'd0}, 1'b0, NO_CHECK}
  };

  // receiver: random stall bursts
  always @(posedge clk) begin
    if (!rst_n || rx_odds == 0) begin
      out_stall <= 1'b0;
      rx_hold <= 0;
    end else if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
    end else if ($urandom_range(1, rx_odds) == 1) begin
      out_stall <= 1'b1;
      rx_hold <= $urandom_range(1, 17) - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result check against the oldest pending status
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (status_due.size() == 0) begin
        flag_mismatch("unexpected result beat", out_flight_mode, -1);
      end else begin
        if (out_flight_mode !== status_due[0].mode)
          flag_mismatch("flight_mode", out_flight_mode, status_due[0].mode);
        if (out_battery_low !== status_due[0].low)
          flag_mismatch("battery_low", out_battery_low, status_due[0].low);
        if (out_filtered_mv !== status_due[0].filtered)
          flag_mismatch("filtered_mv", out_filtered_mv, status_due[0].filtered);
        if (out_mode_changed !== status_due[0].changed)
          flag_mismatch("mode_changed", out_mode_changed, status_due[0].changed);
        void'(status_due.pop_front());
      end
      results_seen++;
    end
  end

  // watchdog: no beat on any port for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d results pending",
                 quiet_cycles, status_due.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    int unsigned ph;
    int unsigned n;
    ev_t e;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: short phases so ticks end them quickly
    write_reg(fmbs_pkg::REG_TAKEOFF, 32'd3);
    write_reg(fmbs_pkg::REG_LANDING, 32'd1);
    settings_used++;
    tx_odds = 4;
    rx_odds = 4;
    foreach (dir_rows[i]) drive_event(dir_rows[i].ev, dir_rows[i].typed, dir_rows[i].want);

    // random phases, first two at the register extremes
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      drain();
      case (ph)
        0: load_settings(1, 1, 0, 8191);
        1: load_settings(65535, 65535, 8191, 0);
        default: load_settings($urandom_range(1, 6), $urandom_range(1, 6),
                               $urandom_range(2500, 5500), $urandom_range(2500, 5500));
      endcase
      tx_odds = pick_odds();
      rx_odds = pick_odds();
      for (n = 0; n < PHASE_BEATS; n++) drive_event(pick_event(), 1'b0, NO_CHECK);
    end

    // last part, no idling: long take-off, then land
    drain();
    tx_odds = 0;
    rx_odds = 0;
    load_settings(LONG_TAKEOFF, 2, 0, 8191);
    e = '{fmbs_pkg::KIND_RADIO, fmbs_pkg::CMD_TAKEOFF, 1'b1, 13'd0};
    drive_event(e, 1'b0, NO_CHECK);
    e.kind = fmbs_pkg::KIND_CMD;
    e.cmd = fmbs_pkg::CMD_OFF;
    drive_event(e, 1'b0, NO_CHECK);
    e.cmd = fmbs_pkg::CMD_TAKEOFF;
    drive_event(e, 1'b0, NO_CHECK);
    e.kind = fmbs_pkg::KIND_TICK;
    for (n = 0; n < LONG_TAKEOFF; n++) drive_event(e, 1'b0, NO_CHECK);
    e.kind = fmbs_pkg::KIND_CMD;
    e.cmd = fmbs_pkg::CMD_LAND;
    drive_event(e, 1'b0, NO_CHECK);
    e.kind = fmbs_pkg::KIND_TICK;
    repeat (2) drive_event(e, 1'b0, NO_CHECK);
    for (n = 0; n < 40; n++) drive_event(pick_event(), 1'b0, NO_CHECK);

    // wrap up
    in_valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    $display("covered %0d event beats and %0d result beats over %0d register settings",
             events_sent, results_seen, settings_used);
    $display("including a %0d-tick take-off run with no idling; %0d mismatches",
             LONG_TAKEOFF, mismatches);
    if (mismatches == 0 && status_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* flight_mode_battery_supervisor_core.f */
design/fmbs_pkg.sv
design/fmbs_cell.sv
design/fmbs_avg.sv
design/fmbs_ctrl.sv
design/flight_mode_battery_supervisor_core.sv
verif/flight_mode_battery_supervisor_core_tb.sv
